// ----- src/npes_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest polygon edge search package
// Shared command codes, datapath operations and controller/datapath bundles.
// ----------------------------------------------------------------------------
package npes_pkg;

    localparam int COORD_W = 24;   // signed Q16.8 coordinate
    localparam int DIFF_W  = 25;   // coordinate difference
    localparam int MUL_W   = 26;   // multiplier operand
    localparam int PROD_W  = 52;   // multiplier product and wide accumulators
    localparam int T_W     = 17;   // clamped parameter, 65536 means 1.0
    localparam int OID_W   = 16;   // id width on the result channel
    localparam int DIV_STEPS = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_START = 4'd1,
        OP_LOAD  = 4'd2,
        OP_LEN_A = 4'd3,
        OP_LEN_B = 4'd4,
        OP_DOT_A = 4'd5,
        OP_DOT_B = 4'd6,
        OP_DOT_C = 4'd7,
        OP_CLAMP = 4'd8,
        OP_DIV   = 4'd9,
        OP_PX    = 4'd10,
        OP_PY    = 4'd11,
        OP_EX    = 4'd12,
        OP_EY    = 4'd13,
        OP_UPD   = 4'd14,
        OP_OUT   = 4'd15
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   wr_en;
    } dp_cmd_t;

    typedef struct packed {
        logic div_needed;
    } dp_stat_t;

endpackage

// ----- src/npes_datapath.sv -----
// ----------------------------------------------------------------------------
// Nearest polygon edge search datapath
// Vertex memory, shared multiplier, restoring divider and best-edge registers.
// ----------------------------------------------------------------------------
module npes_datapath #(
    parameter int MAX_VERTS = 64,
    parameter int ID_WIDTH  = 16,
    parameter int AW        = 6
) (
    input  logic                     aclk,
    input  npes_pkg::dp_cmd_t        cmd,
    output npes_pkg::dp_stat_t       stat,
    input  logic [AW-1:0]            wr_addr,
    input  logic [AW-1:0]            rd_i,
    input  logic [AW-1:0]            rd_j,
    input  logic [15:0]              in_id,
    input  logic [23:0]              in_x,
    input  logic [23:0]              in_y,
    output logic                     out_found,
    output logic [15:0]              out_id,
    output logic [23:0]              out_x,
    output logic [23:0]              out_y
);
    import npes_pkg::*;

    logic [ID_WIDTH-1:0] mem_id [MAX_VERTS];
    logic [COORD_W-1:0]  mem_x  [MAX_VERTS];
    logic [COORD_W-1:0]  mem_y  [MAX_VERTS];

    logic [ID_WIDTH-1:0]       id_i_reg;
    logic signed [COORD_W-1:0] xi_reg, yi_reg, xj_reg, yj_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg, x0_reg, y0_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, ax_reg, ay_reg;
    logic signed [PROD_W-1:0]  prod_reg, dot_reg;
    logic [PROD_W-1:0]         len2_reg, rem_reg, d_reg, best_d_reg;
    logic [T_W-1:0]            t_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, best_x_reg, best_y_reg;
    logic [ID_WIDTH-1:0]       best_id_reg;
    logic                      have_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p, rnd, rnd_sh;
    logic signed [DIFF_W-1:0]  ex, ey;
    logic [PROD_W-1:0]         rem_sh, d_full, dot_u;
    logic                      dot_pos;

    // Memory write and two registered read ports.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_id[wr_addr] <= ID_WIDTH'(in_id);
            mem_x[wr_addr]  <= in_x;
            mem_y[wr_addr]  <= in_y;
        end
        id_i_reg <= mem_id[rd_i];
        xi_reg   <= mem_x[rd_i];
        yi_reg   <= mem_y[rd_i];
        xj_reg   <= mem_x[rd_j];
        yj_reg   <= mem_y[rd_j];
    end

    assign ex      = {qx_reg[COORD_W-1], qx_reg} - {px_reg[COORD_W-1], px_reg};
    assign ey      = {qy_reg[COORD_W-1], qy_reg} - {py_reg[COORD_W-1], py_reg};
    assign dot_u   = dot_reg;
    assign dot_pos = !dot_reg[PROD_W-1] && (dot_reg != '0);
    assign rem_sh  = {rem_reg[PROD_W-2:0], 1'b0};
    assign d_full  = d_reg + prod_reg;
    // Round half toward +infinity, then floor by an arithmetic shift.
    assign rnd     = prod_reg + PROD_W'(32768);
    assign rnd_sh  = rnd >>> 16;

    assign stat.div_needed = (len2_reg != '0) && dot_pos && (dot_u < len2_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_LEN_A: begin mul_a = MUL_W'(dx_reg); mul_b = MUL_W'(dx_reg); end
            OP_LEN_B: begin mul_a = MUL_W'(dy_reg); mul_b = MUL_W'(dy_reg); end
            OP_DOT_A: begin mul_a = MUL_W'(ax_reg); mul_b = MUL_W'(dx_reg); end
            OP_DOT_B: begin mul_a = MUL_W'(ay_reg); mul_b = MUL_W'(dy_reg); end
            OP_PX:    begin mul_a = {9'd0, t_reg};  mul_b = MUL_W'(dx_reg); end
            OP_PY:    begin mul_a = {9'd0, t_reg};  mul_b = MUL_W'(dy_reg); end
            OP_EX:    begin mul_a = MUL_W'(ex);     mul_b = MUL_W'(ex);     end
            OP_EY:    begin mul_a = MUL_W'(ey);     mul_b = MUL_W'(ey);     end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (cmd.op)
            OP_START: begin
                qx_reg      <= in_x;
                qy_reg      <= in_y;
                have_reg    <= 1'b0;
                best_id_reg <= '0;
                best_x_reg  <= '0;
                best_y_reg  <= '0;
                best_d_reg  <= '0;
            end
            OP_LOAD: begin
                x0_reg <= xi_reg;
                y0_reg <= yi_reg;
                dx_reg <= {xj_reg[COORD_W-1], xj_reg} - {xi_reg[COORD_W-1], xi_reg};
                dy_reg <= {yj_reg[COORD_W-1], yj_reg} - {yi_reg[COORD_W-1], yi_reg};
                ax_reg <= {qx_reg[COORD_W-1], qx_reg} - {xi_reg[COORD_W-1], xi_reg};
                ay_reg <= {qy_reg[COORD_W-1], qy_reg} - {yi_reg[COORD_W-1], yi_reg};
            end
            OP_LEN_B: len2_reg <= prod_reg;
            OP_DOT_A: len2_reg <= len2_reg + prod_reg;
            OP_DOT_B: dot_reg  <= prod_reg;
            OP_DOT_C: dot_reg  <= dot_reg + prod_reg;
            OP_CLAMP: begin
                rem_reg <= dot_u;
                if ((len2_reg == '0) || !dot_pos) begin
                    t_reg <= '0;
                end else if (dot_u >= len2_reg) begin
                    t_reg <= T_W'(65536);
                end else begin
                    t_reg <= '0;
                end
            end
            OP_DIV: begin
                if (rem_sh >= len2_reg) begin
                    rem_reg <= rem_sh - len2_reg;
                    t_reg   <= {t_reg[T_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    t_reg   <= {t_reg[T_W-2:0], 1'b0};
                end
            end
            OP_PY: px_reg <= x0_reg + rnd_sh[COORD_W-1:0];
            OP_EX: py_reg <= y0_reg + rnd_sh[COORD_W-1:0];
            OP_EY: d_reg  <= prod_reg;
            OP_UPD: begin
                // Strictly nearer wins, so the first edge keeps a tie.
                if (!have_reg || (d_full < best_d_reg)) begin
                    have_reg    <= 1'b1;
                    best_d_reg  <= d_full;
                    best_id_reg <= id_i_reg;
                    best_x_reg  <= px_reg;
                    best_y_reg  <= py_reg;
                end
            end
            OP_OUT: begin
                out_found <= have_reg;
                out_id    <= OID_W'(best_id_reg);
                out_x     <= best_x_reg;
                out_y     <= best_y_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/npes_ctrl.sv -----
// ----------------------------------------------------------------------------
// Nearest polygon edge search controller
// Command decode, vertex count, edge walk sequencing and result handshake.
// ----------------------------------------------------------------------------
module npes_ctrl #(
    parameter int MAX_VERTS = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [1:0]               s_cmd,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output npes_pkg::dp_cmd_t        dp_cmd,
    input  npes_pkg::dp_stat_t       dp_stat,
    output logic [AW-1:0]            wr_addr,
    output logic [AW-1:0]            rd_i,
    output logic [AW-1:0]            rd_j
);
    import npes_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_READ  = 16'h0002,
        ST_LOAD  = 16'h0004,
        ST_LEN_A = 16'h0008,
        ST_LEN_B = 16'h0010,
        ST_DOT_A = 16'h0020,
        ST_DOT_B = 16'h0040,
        ST_DOT_C = 16'h0080,
        ST_CLAMP = 16'h0100,
        ST_DIV   = 16'h0200,
        ST_PX    = 16'h0400,
        ST_PY    = 16'h0800,
        ST_EX    = 16'h1000,
        ST_EY    = 16'h2000,
        ST_UPD   = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [3:0]    step_reg, step_next;
    logic          m_valid_reg, m_valid_next;
    logic [CW-1:0] idx_inc;
    logic          accept, last_edge, out_free;
    cmd_t          in_cmd;

    assign in_cmd    = cmd_t'(s_cmd);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign last_edge = (idx_inc >= count_reg);
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_i      = idx_reg;
    assign rd_j      = last_edge ? '0 : idx_inc[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        dp_cmd.op    = OP_IDLE;
        dp_cmd.wr_en = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_CLEAR: count_next = '0;
                        CMD_APPEND: begin
                            if (count_reg < CW'(MAX_VERTS)) begin
                                dp_cmd.wr_en = 1'b1;
                                count_next   = count_reg + CW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            dp_cmd.op  = OP_START;
                            idx_next   = '0;
                            state_next = (count_reg == '0) ? ST_OUT : ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD: begin
                dp_cmd.op  = OP_LOAD;
                state_next = ST_LEN_A;
            end
            ST_LEN_A: begin dp_cmd.op = OP_LEN_A; state_next = ST_LEN_B; end
            ST_LEN_B: begin dp_cmd.op = OP_LEN_B; state_next = ST_DOT_A; end
            ST_DOT_A: begin dp_cmd.op = OP_DOT_A; state_next = ST_DOT_B; end
            ST_DOT_B: begin dp_cmd.op = OP_DOT_B; state_next = ST_DOT_C; end
            ST_DOT_C: begin dp_cmd.op = OP_DOT_C; state_next = ST_CLAMP; end
            ST_CLAMP: begin
                dp_cmd.op  = OP_CLAMP;
                step_next  = '0;
                state_next = dp_stat.div_needed ? ST_DIV : ST_PX;
            end
            ST_DIV: begin
                dp_cmd.op = OP_DIV;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(DIV_STEPS - 1)) begin
                    state_next = ST_PX;
                end
            end
            ST_PX: begin dp_cmd.op = OP_PX; state_next = ST_PY; end
            ST_PY: begin dp_cmd.op = OP_PY; state_next = ST_EX; end
            ST_EX: begin dp_cmd.op = OP_EX; state_next = ST_EY; end
            ST_EY: begin dp_cmd.op = OP_EY; state_next = ST_UPD; end
            ST_UPD: begin
                dp_cmd.op = OP_UPD;
                if (last_edge) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_inc[AW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    dp_cmd.op    = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/nearest_polygon_edge_search_core.sv -----
// ----------------------------------------------------------------------------
// Nearest polygon edge search core
// Stores one closed polygon and finds the edge nearest to a query point.
// ----------------------------------------------------------------------------
// Usage: every word on the slave side carries a command in s_tuser. A clear
// word empties the vertex list, an append word stores a vertex id and its
// Q16.8 coordinates (ignored once MAX_VERTS vertices are held), and a query
// word walks all edges, including the closing edge from the last vertex back
// to the first. Only a query produces a master-side word: found in m_tuser,
// and the start vertex id plus the projected point in m_tdata.
// Clear and append leave the core idle, ready for the next word. A query
// walks the edges in turn over the shared multiplier: it loads the vertices,
// forms the squared length and dot product, clamps the parameter, runs the
// one-bit-per-cycle restoring divider only when the projection parameter
// needs it, projects, measures and updates the best edge, then loads the
// output register. An empty list skips the walk and answers with found low.
// Reset empties the list; memory contents are not cleared. While a result
// word waits on a stalled receiver the core still accepts the next command;
// a further query finishes its walk and then holds until the output is free.
// ----------------------------------------------------------------------------
module nearest_polygon_edge_search_core #(
    parameter int MAX_VERTS = 64,
    parameter int ID_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vertex_id[15:0], coord_x[39:16], coord_y[63:40]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // nearest_id[15:0], proj_x[39:16], proj_y[63:40]
    output logic [0:0]  m_tuser    // found[0]
);
    import npes_pkg::*;

    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);

    dp_cmd_t       dp_cmd;
    dp_stat_t      dp_stat;
    logic [AW-1:0] wr_addr, rd_i, rd_j;
    logic          out_found;
    logic [15:0]   out_id;
    logic [23:0]   out_x, out_y;

    npes_ctrl #(
        .MAX_VERTS (MAX_VERTS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat),
        .wr_addr  (wr_addr),
        .rd_i     (rd_i),
        .rd_j     (rd_j)
    );

    npes_datapath #(
        .MAX_VERTS (MAX_VERTS),
        .ID_WIDTH  (ID_WIDTH),
        .AW        (AW)
    ) u_datapath (
        .aclk      (aclk),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .wr_addr   (wr_addr),
        .rd_i      (rd_i),
        .rd_j      (rd_j),
        .in_id     (s_tdata[15:0]),
        .in_x      (s_tdata[39:16]),
        .in_y      (s_tdata[63:40]),
        .out_found (out_found),
        .out_id    (out_id),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    assign m_tdata    = {out_y, out_x, out_id};
    assign m_tuser[0] = out_found;

endmodule
